// ----- sv/ole_pkg.sv -----
// Shared types and constants for the ordered list engine.
// Used by the front end, the request queue and the back end; no other dependencies.
package ole_pkg;

    typedef enum logic [2:0] {
        REQ_INS_TAIL = 3'd0,
        REQ_REM_TAIL = 3'd1,
        REQ_INS_HEAD = 3'd2,
        REQ_REM_HEAD = 3'd3,
        REQ_INS_KEY  = 3'd4,
        REQ_REM_KEY  = 3'd5,
        REQ_READ     = 3'd6,
        REQ_NONE     = 3'd7
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        t_req        req;
        logic [31:0] value;
        logic [31:0] key;
    } t_cmd;

    typedef enum logic [1:0] {
        BE_IDLE = 2'd0,
        BE_EXEC = 2'd1,
        BE_READ = 2'd2
    } t_be_state;

endpackage

// ----- sv/ordered_list_engine.sv -----
// Ordered list engine: each request goes through the front register, request queue
// and back end to its status result; a read out then gives one result per entry
// each cycle while the output is free. The back end takes a new request only when
// idle; the front register and two-entry queue accept up to three further requests
// while it works. The search compare runs the cycle a request enters the back end.
// Synchronous active-low reset empties the list; entry contents are not cleared.
module ordered_list_engine #(
    parameter int DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [31:0] i_value,
    input  logic [31:0] i_key,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_data,
    output logic [1:0]  o_status,
    output logic        o_last
);
    import ole_pkg::*;

    t_cmd w_f_cmd;
    logic w_f_valid;
    logic w_f_ready;
    t_cmd w_q_cmd;
    logic w_q_valid;
    logic w_q_ready;

    ole_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_type  (i_req_type),
        .i_value     (i_value),
        .i_key       (i_key),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .o_cmd       (w_f_cmd),
        .o_cmd_valid (w_f_valid),
        .i_cmd_ready (w_f_ready)
    );

    ole_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_f_cmd),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .o_cmd   (w_q_cmd),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready)
    );

    ole_back #(.DEPTH(DEPTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_q_cmd),
        .i_valid  (w_q_valid),
        .o_ready  (w_q_ready),
        .o_data   (o_data),
        .o_status (o_status),
        .o_last   (o_last),
        .o_valid  (o_valid),
        .i_ready  (i_ready)
    );
endmodule

// ----- sv/ole_front.sv -----
// Front end of the ordered list engine: accepts requests and classifies the type.
// Depends on ole_pkg.
module ole_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [2:0]    i_req_type,
    input  logic [31:0]   i_value,
    input  logic [31:0]   i_key,
    input  logic          i_valid,
    output logic          o_ready,
    output ole_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready
);
    import ole_pkg::*;

    logic r_full;
    logic n_full;
    t_cmd r_cmd;
    t_cmd n_cmd;

    assign o_ready     = !r_full || i_cmd_ready;
    assign o_cmd_valid = r_full;
    assign o_cmd       = r_cmd;

    always_comb begin
        n_full = r_full;
        n_cmd  = r_cmd;
        if (r_full && i_cmd_ready) begin
            n_full = 1'b0;
        end
        if (i_valid && o_ready) begin
            n_full      = 1'b1;
            n_cmd.req   = t_req'(i_req_type);
            n_cmd.value = i_value;
            n_cmd.key   = i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else begin
            r_full <= n_full;
        end
        r_cmd <= n_cmd;
    end
endmodule

// ----- sv/ole_queue.sv -----
// Two-entry request queue between the front end and the back end.
// Depends on ole_pkg.
module ole_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ole_pkg::t_cmd i_cmd,
    input  logic          i_valid,
    output logic          o_ready,
    output ole_pkg::t_cmd o_cmd,
    output logic          o_valid,
    input  logic          i_ready
);
    import ole_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_wp;
    logic       n_rp;
    logic [1:0] n_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wp  = w_push ? !r_wp : r_wp;
        n_rp  = w_pop ? !r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end
endmodule

// ----- sv/ole_back.sv -----
// Back end of the ordered list engine: holds the entries in registers, does the
// parallel compare and shift, and drives the result register. Depends on ole_pkg.
module ole_back #(
    parameter int DEPTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ole_pkg::t_cmd i_cmd,
    input  logic          i_valid,
    output logic          o_ready,
    output logic [31:0]   o_data,
    output logic [1:0]    o_status,
    output logic          o_last,
    output logic          o_valid,
    input  logic          i_ready
);
    import ole_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    t_be_state   r_state;
    t_be_state   n_state;
    t_cmd        r_cmd;
    logic [31:0] r_ent [DEPTH];
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_pos;
    logic [CW-1:0] r_rd;
    logic        r_found;
    logic        r_ovalid;
    logic [31:0] r_odata;
    logic [1:0]  r_ostat;
    logic        r_olast;

    logic        w_out_free;
    logic        w_found;
    logic [CW-1:0] w_pos;
    logic        w_take;
    logic        w_exec;
    logic        w_rd_step;
    logic        w_ins;
    logic        w_rem;
    logic [CW-1:0] w_at;
    t_status     w_st;

    assign w_out_free = !r_ovalid || i_ready;
    assign o_ready    = (r_state == BE_IDLE);
    assign w_take     = i_valid && o_ready;
    assign o_valid    = r_ovalid;
    assign o_data     = r_odata;
    assign o_status   = r_ostat;
    assign o_last     = r_olast;

    // Priority search for the first matching entry, registered for execute.
    always_comb begin
        w_found = 1'b0;
        w_pos   = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if ((CW'(i) < r_cnt) && (r_ent[i] == i_cmd.key)) begin
                w_found = 1'b1;
                w_pos   = CW'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BE_IDLE: begin
                if (w_take) begin
                    n_state = BE_EXEC;
                end
            end
            BE_EXEC: begin
                if (w_out_free) begin
                    if (r_cmd.req == REQ_READ && r_cnt != '0) begin
                        n_state = BE_READ;
                    end else begin
                        n_state = BE_IDLE;
                    end
                end
            end
            BE_READ: begin
                if (w_out_free && (r_rd + CW'(1) == r_cnt)) begin
                    n_state = BE_IDLE;
                end
            end
            default: n_state = BE_IDLE;
        endcase
    end

    always_comb begin
        w_exec    = (r_state == BE_EXEC) && w_out_free;
        w_rd_step = (r_state == BE_READ) && w_out_free;
        w_ins     = 1'b0;
        w_rem     = 1'b0;
        w_at      = '0;
        w_st      = ST_OK;
        case (r_cmd.req)
            REQ_INS_TAIL, REQ_INS_HEAD: begin
                if (r_cnt == CW'(DEPTH)) begin
                    w_st = ST_FULL;
                end else begin
                    w_ins = 1'b1;
                    w_at  = (r_cmd.req == REQ_INS_TAIL) ? r_cnt : '0;
                end
            end
            REQ_REM_TAIL, REQ_REM_HEAD: begin
                if (r_cnt == '0) begin
                    w_st = ST_EMPTY;
                end else begin
                    w_rem = 1'b1;
                    w_at  = (r_cmd.req == REQ_REM_TAIL) ? r_cnt - CW'(1) : '0;
                end
            end
            REQ_INS_KEY: begin
                if (r_cnt == CW'(DEPTH)) begin
                    w_st = ST_FULL;
                end else if (r_cnt == '0) begin
                    w_st = ST_EMPTY;
                end else if (!r_found) begin
                    w_st = ST_NOT_FOUND;
                end else begin
                    w_ins = 1'b1;
                    w_at  = r_pos;
                end
            end
            REQ_REM_KEY: begin
                if (r_cnt == '0) begin
                    w_st = ST_EMPTY;
                end else if (!r_found) begin
                    w_st = ST_NOT_FOUND;
                end else begin
                    w_rem = 1'b1;
                    w_at  = r_pos;
                end
            end
            REQ_READ: begin
                if (r_cnt == '0) begin
                    w_st = ST_EMPTY;
                end
            end
            default: w_st = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BE_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((w_exec && !(r_cmd.req == REQ_READ && r_cnt != '0)) || w_rd_step) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (w_exec) begin
                if (w_ins) begin
                    r_cnt <= r_cnt + CW'(1);
                end else if (w_rem) begin
                    r_cnt <= r_cnt - CW'(1);
                end
            end
        end
        if (w_take) begin
            r_cmd   <= i_cmd;
            r_found <= w_found;
            r_pos   <= w_pos;
            r_rd    <= '0;
        end
        if (w_exec) begin
            r_odata <= '0;
            r_ostat <= w_st;
            r_olast <= 1'b1;
            for (int i = 0; i < DEPTH; i++) begin
                if (w_ins) begin
                    if (CW'(i) == w_at) begin
                        r_ent[i] <= r_cmd.value;
                    end else if (CW'(i) > w_at && i > 0) begin
                        r_ent[i] <= r_ent[(i > 0) ? i - 1 : 0];
                    end
                end else if (w_rem) begin
                    if (CW'(i) >= w_at && i < DEPTH - 1) begin
                        r_ent[i] <= r_ent[(i < DEPTH - 1) ? i + 1 : i];
                    end
                end
            end
        end
        if (w_rd_step) begin
            r_odata <= r_ent[r_rd[IW-1:0]];
            r_ostat <= ST_OK;
            r_olast <= (r_rd + CW'(1) == r_cnt);
            r_rd    <= r_rd + CW'(1);
        end
    end
endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the ordered list engine.
// Depends on ole_pkg and ordered_list_engine; predicts every result from its own list copy.
module testbench;
    import ole_pkg::*;

    localparam int DEPTH = 32;
    localparam int LIMIT = 400000;

    typedef struct {
        logic [31:0] data;
        t_status     status;
        logic        last;
    } t_result;

    typedef struct {
        t_req        req;
        logic [31:0] value;
        logic [31:0] key;
        bit          typed;
        t_status     status;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_req_type = '0;
    logic [31:0] i_value = '0;
    logic [31:0] i_key = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_data;
    logic [1:0]  o_status;
    logic        o_last;

    logic [31:0] list_q[$];
    t_result     pending_q[$];
    int          errors = 0;
    int          cycles = 0;
    int          results_seen = 0;
    int          sent = 0;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          hold_off = 0;
    bit          done = 1'b0;

    ordered_list_engine #(.DEPTH(DEPTH)) dut (.*);

    always #2 i_clk = ~i_clk;

    function automatic int find_first(logic [31:0] k);
        foreach (list_q[i]) if (list_q[i] == k) return i;
        return -1;
    endfunction

    function automatic void push_status(t_status s);
        t_result r;
        r.data = '0;
        r.status = s;
        r.last = 1'b1;
        pending_q.push_back(r);
    endfunction

    function automatic void apply_request(t_req req, logic [31:0] v, logic [31:0] k);
        int pos;
        t_result r;
        case (req)
            REQ_INS_TAIL, REQ_INS_HEAD: begin
                if (list_q.size() >= DEPTH) push_status(ST_FULL);
                else begin
                    if (req == REQ_INS_TAIL) list_q.push_back(v);
                    else list_q.push_front(v);
                    push_status(ST_OK);
                end
            end
            REQ_REM_TAIL, REQ_REM_HEAD: begin
                if (list_q.size() == 0) push_status(ST_EMPTY);
                else begin
                    if (req == REQ_REM_TAIL) void'(list_q.pop_back());
                    else void'(list_q.pop_front());
                    push_status(ST_OK);
                end
            end
            REQ_INS_KEY: begin
                pos = find_first(k);
                if (list_q.size() >= DEPTH) push_status(ST_FULL);
                else if (list_q.size() == 0) push_status(ST_EMPTY);
                else if (pos < 0) push_status(ST_NOT_FOUND);
                else begin
                    list_q.insert(pos, v);
                    push_status(ST_OK);
                end
            end
            REQ_REM_KEY: begin
                pos = find_first(k);
                if (list_q.size() == 0) push_status(ST_EMPTY);
                else if (pos < 0) push_status(ST_NOT_FOUND);
                else begin
                    list_q.delete(pos);
                    push_status(ST_OK);
                end
            end
            REQ_READ: begin
                if (list_q.size() == 0) push_status(ST_EMPTY);
                else foreach (list_q[i]) begin
                    r.data = list_q[i];
                    r.status = ST_OK;
                    r.last = (i == list_q.size() - 1);
                    pending_q.push_back(r);
                end
            end
            default: push_status(ST_OK);
        endcase
    endfunction

    task automatic send(t_req req, logic [31:0] v, logic [31:0] k);
        if (send_idle > 0) begin
            while ($urandom_range(99) < send_idle) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_req_type <= req;
        i_value <= v;
        i_key <= k;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        apply_request(req, v, k);
        sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_item(int flavor);
        t_req req;
        logic [31:0] v;
        logic [31:0] k;
        int r;
        r = $urandom_range(99);
        if (r < 30) req = (list_q.size() < DEPTH - 2) ? REQ_INS_TAIL : REQ_REM_HEAD;
        else if (r < 45) req = REQ_INS_HEAD;
        else if (r < 55) req = REQ_REM_TAIL;
        else if (r < 62) req = REQ_REM_HEAD;
        else if (r < 75) req = REQ_INS_KEY;
        else if (r < 88) req = REQ_REM_KEY;
        else if (r < 97) req = REQ_READ;
        else req = REQ_NONE;
        v = (flavor == 0) ? $urandom_range(15) : $urandom;
        if (list_q.size() != 0 && $urandom_range(3) != 0)
            k = list_q[$urandom_range(list_q.size() - 1)];
        else k = (flavor == 0) ? $urandom_range(15) : $urandom;
        send(req, v, k);
    endtask

    always @(posedge i_clk) begin
        t_result e;
        cycles <= cycles + 1;
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
        end
        if (o_valid && i_ready && i_rst_n) begin
            results_seen <= results_seen + 1;
            if (pending_q.size() == 0) begin
                $error("result with nothing expected: data %h status %0d last %0d",
                       o_data, o_status, o_last);
                errors++;
            end else begin
                e = pending_q.pop_front();
                if (o_data !== e.data) begin
                    $error("data: expected %h, actual %h", e.data, o_data);
                    errors++;
                end
                if (o_status !== e.status) begin
                    $error("status: expected %0d, actual %0d", e.status, o_status);
                    errors++;
                end
                if (o_last !== e.last) begin
                    $error("last: expected %0d, actual %0d", e.last, o_last);
                    errors++;
                end
            end
        end
        if (cycles > LIMIT && !done) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        t_row rows[$];
        t_row row;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows.push_back('{REQ_REM_TAIL, 0, 0, 1, ST_EMPTY});
        rows.push_back('{REQ_REM_HEAD, 0, 0, 1, ST_EMPTY});
        rows.push_back('{REQ_INS_KEY, 5, 5, 1, ST_EMPTY});
        rows.push_back('{REQ_REM_KEY, 0, 5, 1, ST_EMPTY});
        rows.push_back('{REQ_READ, 0, 0, 1, ST_EMPTY});
        rows.push_back('{REQ_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_OK});
        rows.push_back('{REQ_INS_TAIL, 32'h7FFF_FFFF, 0, 1, ST_OK});
        rows.push_back('{REQ_INS_HEAD, 32'h8000_0000, 0, 1, ST_OK});
        rows.push_back('{REQ_INS_TAIL, 32'hFFFF_FFFF, 0, 1, ST_OK});
        rows.push_back('{REQ_INS_TAIL, 0, 0, 1, ST_OK});
        rows.push_back('{REQ_READ, 0, 0, 0, ST_OK});
        rows.push_back('{REQ_INS_KEY, 7, 32'h8000_0000, 1, ST_OK});
        rows.push_back('{REQ_INS_KEY, 9, 32'h1234_5678, 1, ST_NOT_FOUND});
        rows.push_back('{REQ_REM_KEY, 0, 32'h5555_5555, 1, ST_NOT_FOUND});
        rows.push_back('{REQ_INS_KEY, 3, 32'hFFFF_FFFF, 1, ST_OK});
        rows.push_back('{REQ_REM_KEY, 0, 7, 1, ST_OK});
        rows.push_back('{REQ_REM_KEY, 0, 32'h7FFF_FFFF, 1, ST_OK});
        rows.push_back('{REQ_REM_HEAD, 0, 0, 1, ST_OK});
        rows.push_back('{REQ_REM_TAIL, 0, 0, 1, ST_OK});
        rows.push_back('{REQ_READ, 0, 0, 0, ST_OK});
        foreach (rows[i]) begin
            row = rows[i];
            send(row.req, row.value, row.key);
            if (row.typed && pending_q[$].status != row.status) begin
                $error("status: expected %0d, actual %0d", row.status,
                       pending_q[$].status);
                errors++;
            end
        end

        // Fill to capacity, then probe the full cases and read everything out.
        while (list_q.size() < DEPTH) send(REQ_INS_TAIL, $urandom, 0);
        send(REQ_INS_TAIL, 1, 0);
        send(REQ_INS_HEAD, 2, 0);
        send(REQ_INS_KEY, 3, list_q[0]);
        send(REQ_READ, 0, 0);
        wait_drained();

        // Receiver holds off while the sender keeps offering requests.
        hold_off = 300;
        repeat (12) random_item(1);
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 28 : (phase == 1) ? 88 : 0;
            recv_idle = (phase == 0) ? 88 : (phase == 1) ? 28 : 0;
            for (int n = 0; n < 115; n++) random_item(n % 3);
            wait_drained();
        end
        send_idle = 0;
        recv_idle = 0;
        while (list_q.size() != 0) send(REQ_REM_HEAD, 0, 0);
        send(REQ_READ, 0, 0);

        wait_drained();
        repeat (40) @(posedge i_clk);
        done = 1'b1;
        $display("Sent %0d requests, checked %0d results in %0d cycles.",
                 sent, results_seen, cycles);
        if (errors == 0 && pending_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
